// ===== rtl/core/assert_macros.svh =====
// Assertion shorthands used by range_sensor_grid_update.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define RSGU_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition is followed in the next cycle by an effect.
`define RSGU_ASSERT_NEXT(lbl, clk, rst, cause, effect, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error(msg);

`endif

// ===== rtl/core/rsgu_pkg.sv =====
package rsgu_pkg;

  // Field widths of the channels
  localparam int ROW_W      = 6;
  localparam int COL_W      = 6;
  localparam int DIST_W     = 7;
  localparam int CHG_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Default grid and reading limits
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;
  localparam int DEF_MAX_DIST = 127;

  // Cell codes
  typedef logic [1:0] cell_t;
  localparam cell_t CELL_UNKNOWN = 2'd0;
  localparam cell_t CELL_FREE    = 2'd1;
  localparam cell_t CELL_WALL    = 2'd2;
  localparam cell_t CELL_SENSED  = 2'd3;

  // Ray directions, in the order they are walked
  typedef logic [1:0] dir_t;
  localparam dir_t DIR_UP    = 2'd0;
  localparam dir_t DIR_DOWN  = 2'd1;
  localparam dir_t DIR_LEFT  = 2'd2;
  localparam dir_t DIR_RIGHT = 2'd3;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_RANGE = 2'd2;

  localparam logic [CFG_DATA_W-1:0] RST_NUM_ROWS     = 7'd64;
  localparam logic [CFG_DATA_W-1:0] RST_NUM_COLS     = 7'd64;
  localparam logic [CFG_DATA_W-1:0] RST_SENSOR_RANGE = 7'd10;

endpackage

// ===== rtl/core/rsgu_intf.sv =====
// Sensor item channel: robot position and four range readings.
interface rsgu_in_if;
  logic                         valid;
  logic                         ready;
  logic [rsgu_pkg::ROW_W-1:0]  row;
  logic [rsgu_pkg::COL_W-1:0]  col;
  logic [rsgu_pkg::DIST_W-1:0] dist_up;
  logic [rsgu_pkg::DIST_W-1:0] dist_down;
  logic [rsgu_pkg::DIST_W-1:0] dist_left;
  logic [rsgu_pkg::DIST_W-1:0] dist_right;

  modport source (output valid, row, col, dist_up, dist_down, dist_left, dist_right,
                  input ready);
  modport sink   (input valid, row, col, dist_up, dist_down, dist_left, dist_right,
                  output ready);
endinterface

// Result channel: count of cells turned free and the skip flag.
interface rsgu_out_if;
  logic                        valid;
  logic                        ready;
  logic [rsgu_pkg::CHG_W-1:0] changes;
  logic                        skipped;

  modport source (output valid, changes, skipped, input ready);
  modport sink   (input valid, changes, skipped, output ready);
endinterface

// Configuration write channel.
interface rsgu_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rsgu_pkg::CFG_IDX_W-1:0]  index;
  logic [rsgu_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/rsgu_cell_unit.sv =====
// Shared cell locator: position along a ray, grid bounds check and address.
module rsgu_cell_unit #(
  parameter int MAX_ROWS = rsgu_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = rsgu_pkg::DEF_MAX_COLS,
  parameter int MAX_DIST = rsgu_pkg::DEF_MAX_DIST,
  localparam int KW = $clog2(MAX_DIST + 1),
  localparam int AW = $clog2(MAX_ROWS * MAX_COLS)
) (
  input  logic [rsgu_pkg::CFG_DATA_W-1:0] num_rows,
  input  logic [rsgu_pkg::CFG_DATA_W-1:0] num_cols,
  input  logic [rsgu_pkg::ROW_W-1:0]      row,
  input  logic [rsgu_pkg::COL_W-1:0]      col,
  input  rsgu_pkg::dir_t                   dir,
  input  logic [KW-1:0]                    step,
  output logic                             in_grid,
  output logic [AW-1:0]                    addr
);

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CLW = $clog2(MAX_COLS);
  localparam int CW  = $clog2(64 + MAX_DIST + 128 + MAX_ROWS + MAX_COLS) + 1;

  logic signed [CW-1:0] nr;
  logic signed [CW-1:0] nc;
  logic signed [CW-1:0] row_ext;
  logic signed [CW-1:0] col_ext;
  logic signed [CW-1:0] delta;
  logic signed [CW-1:0] pos_r;
  logic signed [CW-1:0] pos_c;

  // Clamp the grid size in use to 1..MAX
  always_comb begin
    if (num_rows == '0) begin
      nr = CW'(1);
    end else if (CW'(num_rows) > CW'(MAX_ROWS)) begin
      nr = CW'(MAX_ROWS);
    end else begin
      nr = CW'(num_rows);
    end
    if (num_cols == '0) begin
      nc = CW'(1);
    end else if (CW'(num_cols) > CW'(MAX_COLS)) begin
      nc = CW'(MAX_COLS);
    end else begin
      nc = CW'(num_cols);
    end
  end

  // Step away from the robot along the chosen direction
  always_comb begin
    row_ext = $signed(CW'(row));
    col_ext = $signed(CW'(col));
    delta   = $signed(CW'(step));
    pos_r   = row_ext;
    pos_c   = col_ext;
    case (dir)
      rsgu_pkg::DIR_UP:    pos_r = row_ext - delta;
      rsgu_pkg::DIR_DOWN:  pos_r = row_ext + delta;
      rsgu_pkg::DIR_LEFT:  pos_c = col_ext - delta;
      rsgu_pkg::DIR_RIGHT: pos_c = col_ext + delta;
      default: begin
        pos_r = row_ext;
        pos_c = col_ext;
      end
    endcase
  end

  // Bounds check and row-major address
  assign in_grid = !pos_r[CW-1] && (pos_r < nr) && !pos_c[CW-1] && (pos_c < nc);
  assign addr    = AW'(AW'(pos_r[RW-1:0]) * AW'(MAX_COLS) + AW'(pos_c[CLW-1:0]));

endmodule

// ===== rtl/core/rsgu_grid_mem.sv =====
// Grid cell store: one write port, one registered read port.
module rsgu_grid_mem #(
  parameter int DEPTH = rsgu_pkg::DEF_MAX_ROWS * rsgu_pkg::DEF_MAX_COLS,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  rsgu_pkg::cell_t wdata,
  input  logic [AW-1:0]   raddr,
  output rsgu_pkg::cell_t rdata
);

  rsgu_pkg::cell_t mem [DEPTH];

  // Write and read in the same cycle at independent addresses
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/range_sensor_grid_update.sv =====
// Occupancy grid of MAX_ROWS x MAX_COLS two-bit cells updated from four range readings
// per item; after reset the block sweeps every grid cell to unknown and takes no item
// meanwhile, though configuration writes are taken; an item is then taken, the robot cell
// and its neighbours are looked at, each ray is walked, and the result is handed over.
// The grid memory has a single read and a single write port and walks one cell per cycle
// along a ray as a read-modify-write pipeline; the block takes one item at a time.
`include "assert_macros.svh"

module range_sensor_grid_update #(
  parameter int MAX_ROWS = rsgu_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = rsgu_pkg::DEF_MAX_COLS,
  parameter int MAX_DIST = rsgu_pkg::DEF_MAX_DIST
) (
  input  logic       clk,
  input  logic       rst,
  rsgu_cfg_if.sink   cfg,
  rsgu_in_if.sink    sensor,
  rsgu_out_if.source result
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int KW    = $clog2(MAX_DIST + 1);

  localparam logic [7:0] DIST_LIM = 8'(MAX_DIST);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_RAY   = 3'd3;
  localparam logic [2:0] S_WALL  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  // Look phase: centre read, four neighbour reads, then the decision
  localparam logic [2:0] LOOK_FIRST  = 3'd0;
  localparam logic [2:0] LOOK_CENTRE = 3'd1;
  localparam logic [2:0] LOOK_LAST   = 3'd5;

  // Configuration registers
  logic [rsgu_pkg::CFG_DATA_W-1:0] num_rows;
  logic [rsgu_pkg::CFG_DATA_W-1:0] num_cols;
  logic [rsgu_pkg::CFG_DATA_W-1:0] sensor_range;

  // Sequencer state
  logic [2:0]    state, state_next;
  logic [AW-1:0] clr_addr, clr_addr_next;
  logic [2:0]    look_idx, look_idx_next;
  logic          look_pend, look_pend_next;
  logic          open_seen, open_next;
  rsgu_pkg::dir_t ray_dir, ray_dir_next;
  logic [KW-1:0] step, step_next;
  logic          ray_pend, ray_pend_next;
  logic          out_valid;

  // Item and result payload
  logic [rsgu_pkg::ROW_W-1:0] robot_row;
  logic [rsgu_pkg::COL_W-1:0] robot_col;
  logic [KW-1:0]              ray_len [4];
  logic [AW-1:0]              pend_addr, pend_addr_next;
  logic [rsgu_pkg::CHG_W-1:0] count, count_next;
  logic [rsgu_pkg::CHG_W-1:0] res_changes, res_changes_next;
  logic                       res_skipped, res_skipped_next;
  logic [rsgu_pkg::CHG_W-1:0] out_changes;
  logic                       out_skipped;

  // Shared locator and memory hookup
  rsgu_pkg::dir_t  unit_dir;
  logic [KW-1:0]   unit_step;
  logic            unit_in_grid;
  logic [AW-1:0]   unit_addr;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  rsgu_pkg::cell_t mem_wdata;
  rsgu_pkg::cell_t cell_rd;
  logic            load_out;
  logic            accept;

  // Saturate a reading to MAX_DIST
  function automatic logic [KW-1:0] sat_dist(input logic [rsgu_pkg::DIST_W-1:0] raw);
    if (8'(raw) > DIST_LIM) begin
      return KW'(MAX_DIST);
    end
    return KW'(raw);
  endfunction

  rsgu_cell_unit #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .MAX_DIST (MAX_DIST)
  ) u_cell (
    .num_rows (num_rows),
    .num_cols (num_cols),
    .row      (robot_row),
    .col      (robot_col),
    .dir      (unit_dir),
    .step     (unit_step),
    .in_grid  (unit_in_grid),
    .addr     (unit_addr)
  );

  rsgu_grid_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (unit_addr),
    .rdata (cell_rd)
  );

  assign sensor.ready   = (state == S_IDLE);
  assign accept         = sensor.valid && sensor.ready;
  assign cfg.ready      = 1'b1;
  assign result.valid   = out_valid;
  assign result.changes = out_changes;
  assign result.skipped = out_skipped;

  // Sequencer: clear sweep, look phase, ray walks, result hand-over
  always_comb begin
    state_next       = state;
    clr_addr_next    = clr_addr;
    look_idx_next    = look_idx;
    look_pend_next   = look_pend;
    open_next        = open_seen;
    ray_dir_next     = ray_dir;
    step_next        = step;
    ray_pend_next    = ray_pend;
    pend_addr_next   = pend_addr;
    count_next       = count;
    res_changes_next = res_changes;
    res_skipped_next = res_skipped;
    unit_dir         = ray_dir;
    unit_step        = step;
    mem_we           = 1'b0;
    mem_waddr        = unit_addr;
    mem_wdata        = rsgu_pkg::CELL_UNKNOWN;
    load_out         = 1'b0;

    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end else begin
          clr_addr_next = clr_addr + 1'b1;
        end
      end

      S_IDLE: begin
        if (sensor.valid) begin
          state_next     = S_LOOK;
          look_idx_next  = LOOK_FIRST;
          look_pend_next = 1'b0;
          open_next      = 1'b0;
        end
      end

      S_LOOK: begin
        if (look_idx == LOOK_FIRST || look_idx == LOOK_LAST) begin
          unit_dir  = rsgu_pkg::DIR_UP;
          unit_step = '0;
        end else begin
          unit_dir  = 2'(look_idx - 3'd1);
          unit_step = KW'(1);
        end

        if (look_idx == LOOK_FIRST) begin
          // Robot outside the grid: skip without touching it
          if (!unit_in_grid) begin
            state_next       = S_DONE;
            res_changes_next = '0;
            res_skipped_next = 1'b1;
          end else begin
            look_pend_next = 1'b1;
            look_idx_next  = LOOK_CENTRE;
          end
        end else if (look_idx == LOOK_LAST) begin
          if (!(open_seen || (look_pend && cell_rd == rsgu_pkg::CELL_UNKNOWN))) begin
            state_next       = S_DONE;
            res_changes_next = '0;
            res_skipped_next = 1'b1;
          end else begin
            // Mark the robot cell and start on the up ray
            mem_we        = 1'b1;
            mem_wdata     = rsgu_pkg::CELL_SENSED;
            state_next    = S_RAY;
            ray_dir_next  = rsgu_pkg::DIR_UP;
            step_next     = KW'(1);
            ray_pend_next = 1'b0;
            count_next    = '0;
          end
        end else begin
          if (look_idx == LOOK_CENTRE && cell_rd == rsgu_pkg::CELL_SENSED) begin
            state_next       = S_DONE;
            res_changes_next = '0;
            res_skipped_next = 1'b1;
          end else begin
            if (look_idx != LOOK_CENTRE && look_pend &&
                cell_rd == rsgu_pkg::CELL_UNKNOWN) begin
              open_next = 1'b1;
            end
            look_pend_next = unit_in_grid;
            look_idx_next  = look_idx + 3'd1;
          end
        end
      end

      S_RAY: begin
        // Finish the cell read last cycle
        if (ray_pend && cell_rd == rsgu_pkg::CELL_UNKNOWN) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr;
          mem_wdata = rsgu_pkg::CELL_FREE;
          if (count != '1) begin
            count_next = count + 1'b1;
          end
        end
        // Issue the next read, or stop at the reading or the grid edge
        if (step < ray_len[ray_dir] && unit_in_grid) begin
          ray_pend_next  = 1'b1;
          pend_addr_next = unit_addr;
          step_next      = step + 1'b1;
        end else begin
          ray_pend_next = 1'b0;
          state_next    = S_WALL;
        end
      end

      S_WALL: begin
        unit_step = ray_len[ray_dir];
        if (8'(ray_len[ray_dir]) <= 8'(sensor_range) && unit_in_grid) begin
          mem_we    = 1'b1;
          mem_wdata = rsgu_pkg::CELL_WALL;
        end
        if (ray_dir == rsgu_pkg::DIR_RIGHT) begin
          state_next       = S_DONE;
          res_changes_next = count;
          res_skipped_next = 1'b0;
        end else begin
          ray_dir_next = ray_dir + 2'd1;
          step_next    = KW'(1);
          state_next   = S_RAY;
        end
      end

      S_DONE: begin
        // Hold the result until the output register is free
        if (!out_valid || result.ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      look_idx     <= LOOK_FIRST;
      look_pend    <= 1'b0;
      open_seen    <= 1'b0;
      ray_dir      <= rsgu_pkg::DIR_UP;
      step         <= '0;
      ray_pend     <= 1'b0;
      out_valid    <= 1'b0;
      num_rows     <= rsgu_pkg::RST_NUM_ROWS;
      num_cols     <= rsgu_pkg::RST_NUM_COLS;
      sensor_range <= rsgu_pkg::RST_SENSOR_RANGE;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      look_idx  <= look_idx_next;
      look_pend <= look_pend_next;
      open_seen <= open_next;
      ray_dir   <= ray_dir_next;
      step      <= step_next;
      ray_pend  <= ray_pend_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          rsgu_pkg::CFG_NUM_ROWS:     num_rows     <= cfg.data;
          rsgu_pkg::CFG_NUM_COLS:     num_cols     <= cfg.data;
          rsgu_pkg::CFG_SENSOR_RANGE: sensor_range <= cfg.data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_addr   <= pend_addr_next;
    count       <= count_next;
    res_changes <= res_changes_next;
    res_skipped <= res_skipped_next;
    if (accept) begin
      robot_row                    <= sensor.row;
      robot_col                    <= sensor.col;
      ray_len[rsgu_pkg::DIR_UP]    <= sat_dist(sensor.dist_up);
      ray_len[rsgu_pkg::DIR_DOWN]  <= sat_dist(sensor.dist_down);
      ray_len[rsgu_pkg::DIR_LEFT]  <= sat_dist(sensor.dist_left);
      ray_len[rsgu_pkg::DIR_RIGHT] <= sat_dist(sensor.dist_right);
    end
    if (load_out) begin
      out_changes <= res_changes;
      out_skipped <= res_skipped;
    end
  end

  `RSGU_ASSERT_NEXT(a_done_hold, clk, rst, state == S_DONE && out_valid && !result.ready, state == S_DONE, "result dropped while output register busy")
  `RSGU_ASSERT_NEXT(a_accept_look, clk, rst, sensor.valid && sensor.ready, state == S_LOOK && look_idx == LOOK_FIRST, "accepted item did not start the look phase")
  `RSGU_ASSERT(a_skip_zero, clk, rst, result.valid && result.skipped |-> result.changes == '0, "skipped result reports changes")
  `RSGU_ASSERT(a_free_pend, clk, rst, state == S_RAY && mem_we |-> ray_pend && mem_wdata == rsgu_pkg::CELL_FREE, "ray write without a pending read")

endmodule
